// File: src/mpd_pkg.sv
`timescale 1ns / 1ps
package mpd_pkg;

	localparam int VW = 16;
	localparam int EW = 16;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DIVZ   = 2'd1;
	localparam logic [1:0] ST_NOINV  = 2'd2;

	localparam logic OP_POW = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic          op;
		logic [VW-1:0] a_value;
		logic [VW-1:0] divisor;
		logic [EW-1:0] exponent;
	} in_t;

	typedef struct packed {
		logic [VW-1:0] result;
		logic [1:0]    status;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_REDA, S_REDB, S_POWSQ, S_POWMUL, S_EDIV, S_EUPD, S_FIX, S_AMUL, S_DONE
	} state_t;

endpackage

// File: src/mpd_mulmod.sv
`timescale 1ns / 1ps
// serial modular multiply: shift-and-add, one multiplier bit per cycle
module mpd_mulmod #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] m,
	output logic         busy,
	output logic [W-1:0] p
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  y_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    dbl, dbl_r, add, add_r;

	// horner step: acc = 2*acc (+x) mod m, msb first
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		add   = dbl_r + {1'b0, x_q};
		add_r = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= y_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign p    = acc_q;
endmodule

// File: src/mpd_divider.sv
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle
module mpd_divider #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n,
	input  logic [W-1:0] d,
	output logic         busy,
	output logic [W-1:0] q,
	output logic [W-1:0] r
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  n_q, q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	// shift in next dividend bit and try subtract
	assign trial = {r_q, n_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			d_q <= d;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[W-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				r_q <= W'(trial - {1'b0, d_q});
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign q    = q_q;
	assign r    = r_q;
endmodule

// File: src/modular_power_and_division.sv
`timescale 1ns / 1ps
// modular power and division unit over a configured modulus m
// channels: in (in_valid/in_stall, fields in_op to in_exponent), out
// (out_valid/out_stall, fields out_result and out_status), cfg
// (cfg_valid/cfg_ready/cfg_data) writes the modulus; values 0 and 1 act as 1
// one item at a time; each beat gives exactly one result beat
// each serial divide or multiply runs as a launch, a step per bit, then a hand-off
// power: one reduction, then per exponent bit one squaring and, for set bits,
// one multiply; a clear bit skips the multiply; all bits are walked
// divide: two reductions, then extended euclid; each iteration is one serial
// division plus one serial multiply for the coefficient update, then a check
// state and, if an inverse exists, a final multiply by the dividend
// a zero divisor ends after the two reductions
// the result beat is offered in the cycle after the done state
// reset: modulus returns to 2, any item in flight is dropped
// a stalled result holds in the output register; no new beat is taken
// until the result beat leaves
module modular_power_and_division #(
	parameter int VALUE_WIDTH = 16,
	parameter int EXP_WIDTH   = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      in_op,
	input  logic [VALUE_WIDTH-1:0]    in_a_value,
	input  logic [VALUE_WIDTH-1:0]    in_divisor,
	input  logic [EXP_WIDTH-1:0]      in_exponent,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [VALUE_WIDTH-1:0]    out_result,
	output logic [1:0]                out_status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [VALUE_WIDTH-1:0]    cfg_data
);
	import mpd_pkg::*;
	localparam int W = VALUE_WIDTH;

	state_t st_q, st_d;
	logic [W-1:0] mod_q, m_eff;
	logic         op_q;
	logic [W-1:0] a_q, b_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [$clog2(EXP_WIDTH+1)-1:0] ecnt_q;
	logic [W-1:0] acc_q, base_q;
	// euclid: remainders and coefficients mod m
	logic [W-1:0] r0_q, r1_q, s0_q, s1_q, qt_q;
	logic         out_valid_q;
	logic [W-1:0] res_q;
	logic [1:0]   stat_q;
	logic         started_q;

	logic         dv_start, dv_busy, mm_start, mm_busy;
	logic [W-1:0] dv_n, dv_d, dv_q, dv_r, mm_x, mm_y, mm_p;
	logic         accept, unit_busy, unit_done;

	assign m_eff     = (mod_q < W'(2)) ? W'(1) : mod_q;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (st_q != S_IDLE) || out_valid_q;
	assign cfg_ready = 1'b1;
	assign unit_busy = dv_busy || mm_busy;
	assign unit_done = started_q && !unit_busy;

	mpd_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .n(dv_n), .d(dv_d),
		.busy(dv_busy), .q(dv_q), .r(dv_r)
	);

	mpd_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mm_x), .y(mm_y),
		.m(m_eff), .busy(mm_busy), .p(mm_p)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE:   if (accept) st_d = S_REDA;
			S_REDA:   if (unit_done) st_d = (op_q == OP_POW) ? S_POWMUL : S_REDB;
			S_REDB:   if (unit_done) st_d = (dv_r == '0) ? S_DONE : S_EDIV;
			S_POWMUL: if (unit_done) st_d = S_POWSQ;
			S_POWSQ:  if (unit_done)
				st_d = (ecnt_q == ($clog2(EXP_WIDTH+1))'(1)) ? S_DONE : S_POWMUL;
			S_EDIV:   if (unit_done) st_d = S_EUPD;
			S_EUPD:   if (unit_done) st_d = (r1_q == '0) ? S_FIX : S_EDIV;
			S_FIX:    st_d = (r0_q != W'(1)) ? S_DONE : S_AMUL;
			S_AMUL:   if (unit_done) st_d = S_DONE;
			S_DONE:   st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
	end

	// unit launch and operand selection
	always_comb begin
		dv_start = 1'b0;
		mm_start = 1'b0;
		dv_n = a_q;
		dv_d = m_eff;
		mm_x = acc_q;
		mm_y = base_q;
		unique case (st_q)
			S_REDA: begin
				dv_start = !started_q;
			end
			S_REDB: begin
				dv_start = !started_q;
				dv_n = b_q;
			end
			S_POWMUL: begin
				mm_start = !started_q && e_q[0];
			end
			S_POWSQ: begin
				mm_start = !started_q;
				mm_x = base_q;
			end
			S_EDIV: begin
				dv_start = !started_q;
				dv_n = r0_q;
				dv_d = r1_q;
			end
			S_EUPD: begin
				mm_start = !started_q;
				mm_x = qt_q;
				mm_y = s1_q;
			end
			S_AMUL: begin
				mm_start = !started_q;
				mm_x = a_q;
				mm_y = s0_q;
			end
			default: ;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			mod_q       <= W'(2);
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready)
				mod_q <= cfg_data;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (st_q == S_DONE)
				out_valid_q <= 1'b1;
			if (dv_start || mm_start)
				started_q <= 1'b1;
			else if (st_d != st_q || (st_q == S_POWMUL && !e_q[0] && started_q == 1'b0))
				started_q <= (st_q == S_POWMUL && !e_q[0]) ? 1'b1 : 1'b0;
			if (st_d != st_q)
				started_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (accept) begin
				op_q   <= in_op;
				a_q    <= in_a_value;
				b_q    <= in_divisor;
				e_q    <= in_exponent;
				ecnt_q <= ($clog2(EXP_WIDTH+1))'(EXP_WIDTH);
				acc_q  <= (m_eff == W'(1)) ? '0 : W'(1);
				res_q  <= '0;
				stat_q <= ST_OK;
			end
			S_REDA: if (unit_done) begin
				a_q    <= dv_r;
				base_q <= dv_r;
			end
			S_REDB: if (unit_done) begin
				r0_q <= m_eff;
				r1_q <= dv_r;
				s0_q <= '0;
				s1_q <= W'(1);
				if (dv_r == '0)
					stat_q <= ST_DIVZ;
			end
			S_POWMUL: if (unit_done && e_q[0])
				acc_q <= mm_p;
			S_POWSQ: if (unit_done) begin
				base_q <= mm_p;
				e_q    <= e_q >> 1;
				ecnt_q <= ecnt_q - 1'b1;
				if (ecnt_q == ($clog2(EXP_WIDTH+1))'(1))
					ecnt_q <= '0;
				if (ecnt_q == ($clog2(EXP_WIDTH+1))'(1))
					res_q <= acc_q;
			end
			S_EDIV: if (unit_done) begin
				qt_q <= (dv_q >= m_eff) ? dv_q - m_eff : dv_q;
				r0_q <= r1_q;
				r1_q <= dv_r;
			end
			S_EUPD: if (unit_done) begin
				// s_new = s0 - q*s1 mod m
				s0_q <= s1_q;
				s1_q <= (s0_q >= mm_p) ? s0_q - mm_p : W'({1'b0, s0_q} + {1'b0, m_eff} - {1'b0, mm_p});
			end
			S_FIX: if (r0_q != W'(1))
				stat_q <= ST_NOINV;
			S_AMUL: if (unit_done)
				res_q <= mm_p;
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_result = res_q;
	assign out_status = stat_q;
endmodule
